// File: sv/mcc_pkg.sv
// Shared widths and constants for the minimum coin change engine.
package mcc_pkg;

  localparam int unsigned MaxCoins = 128;
  localparam int unsigned CoinAw   = $clog2(MaxCoins);
  localparam int unsigned CntW     = $clog2(MaxCoins + 1);
  localparam int unsigned AmtW     = 16;
  localparam int unsigned BestW    = AmtW + 1;
  localparam int unsigned BestDepth = 2 ** AmtW;

  localparam logic [BestW-1:0] Unreached = BestW'(1) << AmtW;

endpackage

// File: sv/min_coin_change_dp.sv
// Minimum coin change engine: coin store, best-count table and solve sequencer.
// A load transfer never raises the input stall, so the block can accept the next item straight after it.
// A solve walks every amount from 1 to the target: per amount, one coin read per stored coin,
// a drain of the coin-read and table-read registers and one table write-back.
// Input stalls while a solve runs; the result waits in an output register.
// rst_ni clears the control state and the coin count; both memories start undefined.
module min_coin_change_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   mode_i,
  input  logic [mcc_pkg::AmtW-1:0] amount_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [mcc_pkg::AmtW-1:0] min_coins_o,
  output logic                   reachable_o
);
  import mcc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_SOLVE = 1'b1;

  logic [AmtW-1:0]  coin_mem [MaxCoins];
  logic [BestW-1:0] best_mem [BestDepth];

  logic [1:0]       state_q;
  logic [CntW-1:0]  count_q;
  logic             restart_q;
  logic [AmtW-1:0]  target_q;
  logic [AmtW-1:0]  i_q;
  logic [CntW-1:0]  j_q;
  logic             p1_vld_q;
  logic             p2_vld_q;
  logic [AmtW-1:0]  coin_rd_q;
  logic [BestW-1:0] best_rd_q;
  logic [BestW-1:0] best_q;
  logic [BestW-1:0] res_q;
  logic             out_valid_q;
  logic [AmtW-1:0]  min_coins_q;
  logic             reachable_q;

  logic             in_xfer;
  logic             out_xfer;
  logic             load_xfer;
  logic             solve_xfer;
  logic             issue;
  logic             ok1;
  logic [AmtW-1:0]  best_raddr;
  logic [BestW-1:0] cand;
  logic             take;
  logic             step_done;
  logic [CntW-1:0]  eff_count;
  logic             store_coin;
  logic [CntW-1:0]  count_d;
  logic             out_load;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign load_xfer   = in_xfer && (mode_i == MODE_LOAD);
  assign solve_xfer  = in_xfer && (mode_i == MODE_SOLVE);

  assign eff_count   = restart_q ? '0 : count_q;
  assign store_coin  = load_xfer && (amount_i != '0) && (eff_count < CntW'(MaxCoins));
  assign count_d     = store_coin ? eff_count + CntW'(1) : eff_count;

  assign issue       = (state_q == S_RUN) && (j_q < count_q);
  assign ok1         = p1_vld_q && (coin_rd_q != '0) && (coin_rd_q <= i_q);
  assign best_raddr  = i_q - coin_rd_q;
  assign cand        = best_rd_q + BestW'(1);
  assign take        = p2_vld_q && (best_rd_q < Unreached) && (cand < best_q);
  assign step_done   = (state_q == S_RUN) && (j_q == count_q) && !p1_vld_q && !p2_vld_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_xfer);

  // coin store
  always_ff @(posedge clk_i) begin
    if (store_coin) begin
      coin_mem[eff_count[CoinAw-1:0]] <= amount_i;
    end
    if (issue) begin
      coin_rd_q <= coin_mem[j_q[CoinAw-1:0]];
    end
  end

  // best-count table; reads only reach amounts written earlier in the solve
  always_ff @(posedge clk_i) begin
    if (solve_xfer) begin
      best_mem[0] <= '0;
    end else if (step_done) begin
      best_mem[i_q] <= best_q;
    end
    if (ok1) begin
      best_rd_q <= best_mem[best_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      restart_q   <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_vld_q <= issue;
      p2_vld_q <= ok1;
      if (load_xfer) begin
        count_q   <= count_d;
        restart_q <= 1'b0;
      end
      if (solve_xfer) begin
        restart_q <= 1'b1;
        state_q   <= (amount_i == '0) ? S_DONE : S_RUN;
      end else if (step_done && (i_q == target_q)) begin
        state_q <= S_DONE;
      end else if (out_load) begin
        state_q <= S_IDLE;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    if (solve_xfer) begin
      target_q <= amount_i;
      i_q      <= AmtW'(1);
      j_q      <= '0;
      best_q   <= Unreached;
      res_q    <= '0;
    end else if (step_done) begin
      res_q  <= best_q;
      i_q    <= i_q + AmtW'(1);
      j_q    <= '0;
      best_q <= Unreached;
    end else begin
      if (issue) begin
        j_q <= j_q + CntW'(1);
      end
      if (take) begin
        best_q <= cand;
      end
    end
    if (out_load) begin
      reachable_q <= (res_q < Unreached);
      min_coins_q <= (res_q < Unreached) ? res_q[AmtW-1:0] : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_coins_o = min_coins_q;
  assign reachable_o = reachable_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxCoins))
    else $error("coin count above table size");

  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (j_q <= count_q))
    else $error("coin index past coin count");

  a_p2_follows_p1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |-> $past(p1_vld_q))
    else $error("table read without coin read");

  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    solve_xfer |=> (state_q != S_IDLE))
    else $error("solve transfer did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

endmodule

// File: tb/min_coin_change_dp_test.sv
// Self-checking testbench for the minimum coin change engine: predictor, stimulus and checks.
module min_coin_change_dp_test;
  import mcc_pkg::*;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeSolve = 1'b1;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned RandomItems = 1730;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [AmtW-1:0] min_coins;
    logic            reachable;
  } change_t;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic            mode_i;
  logic [AmtW-1:0] amount_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [AmtW-1:0] min_coins_o;
  logic            reachable_o;

  min_coin_change_dp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .amount_i   (amount_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .min_coins_o(min_coins_o),
    .reachable_o(reachable_o)
  );

  // predictor state
  logic [AmtW-1:0]  coin_mem [MaxCoins];
  int unsigned      coin_cnt = 0;
  bit               restart_pending = 1'b0;
  logic [BestW-1:0] best_by_amount [BestDepth];
  change_t          expected_change [$];

  int unsigned items_in = 0;
  int unsigned solves_in = 0;
  int unsigned unreachable_in = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned peak_coins = 0;
  bit          steady = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  change_t     want;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("Verification failed");
    $finish;
  end

  function automatic change_t min_change_for(input logic [AmtW-1:0] target);
    int unsigned amt;
    int unsigned k;
    int unsigned prev_amt;
    logic [AmtW-1:0] coin;
    logic [BestW-1:0] cand;
    logic [BestW-1:0] best;
    change_t r;
    best_by_amount[0] = '0;
    for (amt = 1; amt <= target; amt++) begin
      best = Unreached;
      for (k = 0; k < coin_cnt; k++) begin
        coin = coin_mem[k[CoinAw-1:0]];
        if (coin != 0 && coin <= amt) begin
          prev_amt = amt - coin;
          cand = best_by_amount[prev_amt[AmtW-1:0]];
          if (cand < Unreached && cand + BestW'(1) < best) best = cand + BestW'(1);
        end
      end
      best_by_amount[amt[AmtW-1:0]] = best;
    end
    r.reachable = best_by_amount[target] < Unreached;
    r.min_coins = r.reachable ? best_by_amount[target][AmtW-1:0] : '0;
    return r;
  endfunction

  function automatic void predict_item(input logic mode, input logic [AmtW-1:0] amount);
    change_t r;
    items_in++;
    if (mode == ModeLoad) begin
      if (restart_pending) begin
        coin_cnt = 0;
        restart_pending = 1'b0;
      end
      if (amount != 0 && coin_cnt < MaxCoins) begin
        coin_mem[coin_cnt[CoinAw-1:0]] = amount;
        coin_cnt++;
        if (coin_cnt > peak_coins) peak_coins = coin_cnt;
      end
    end else begin
      restart_pending = 1'b1;
      r = min_change_for(amount);
      solves_in++;
      if (!r.reachable) unreachable_in++;
      expected_change.push_back(r);
    end
  endfunction

  function automatic void note_failure(input string msg);
    mismatches++;
    if (mismatches <= MaxReports) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_change.size() == 0) begin
        note_failure($sformatf("unexpected result min_coins=%0d reachable=%0b",
                               min_coins_o, reachable_o));
      end else begin
        want = expected_change.pop_front();
        results_checked++;
        if (min_coins_o !== want.min_coins || reachable_o !== want.reachable)
          note_failure($sformatf("expected min_coins=%0d reachable=%0b, got %0d %0b",
                                 want.min_coins, want.reachable, min_coins_o, reachable_o));
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < 8);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic mode, input logic [AmtW-1:0] amount);
    while (!steady && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    amount_i   <= amount;
    do @(posedge clk_i); while (in_stall_o);
    predict_item(mode, amount);
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_item(ModeSolve, 16'd0);      // empty set, zero target
    send_item(ModeSolve, 16'd7);      // empty set
    send_item(ModeLoad, 16'd1);
    send_item(ModeLoad, 16'd5);
    send_item(ModeLoad, 16'd10);
    send_item(ModeSolve, 16'd18);
    send_item(ModeSolve, 16'd0);
    send_item(ModeLoad, 16'd0);       // zero coin still restarts the set
    send_item(ModeLoad, 16'd4);
    send_item(ModeLoad, 16'd6);
    send_item(ModeSolve, 16'd7);
    send_item(ModeSolve, 16'd12);
    send_item(ModeLoad, 16'hFFFF);
    send_item(ModeLoad, 16'h8000);
    send_item(ModeLoad, 16'd3);
    send_item(ModeLoad, 16'd3);
    send_item(ModeSolve, 16'd9);
    send_item(ModeSolve, 16'd10);
    send_item(ModeLoad, 16'd7);
    send_item(ModeLoad, 16'd11);
    send_item(ModeSolve, 16'd25);
  endtask

  task automatic test_table_full();
    int unsigned k;
    for (k = 0; k < MaxCoins + 12; k++)
      send_item(ModeLoad, (k % 17 == 5) ? 16'd0 : AmtW'(13 + 3 * k));
    send_item(ModeSolve, 16'd45);
    send_item(ModeSolve, 16'd12);
    // the set is full and a solve happened: the next load restarts it
    send_item(ModeLoad, 16'd3);
    send_item(ModeSolve, 16'd9);
  endtask

  task automatic test_max_target();
    send_item(ModeLoad, 16'd1);
    send_item(ModeSolve, 16'hFFFF);
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_req++;
    send_item(ModeLoad, 16'd2);
    send_item(ModeLoad, 16'd3);
    send_item(ModeSolve, 16'd11);
    send_item(ModeSolve, 16'd7);
    send_item(ModeSolve, 16'd1);
    send_item(ModeLoad, 16'd5);
    send_item(ModeSolve, 16'd9);
    send_item(ModeSolve, 16'd4);
    steady = 1'b0;
  endtask

  function automatic logic [AmtW-1:0] rand_coin();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return AmtW'($urandom_range(1, 30));
    if (pick < 78) return '0;
    if (pick < 90) return AmtW'($urandom_range(31, 255));
    return AmtW'($urandom_range(0, 65535));
  endfunction

  function automatic logic [AmtW-1:0] rand_target();
    if ($urandom_range(99) < 95) return AmtW'($urandom_range(0, 60));
    return AmtW'($urandom_range(61, 400));
  endfunction

  task automatic test_random();
    int unsigned first;
    int unsigned set_size;
    int unsigned n;
    int unsigned k;
    first = items_in;
    while (items_in - first < RandomItems) begin
      steady = (items_in - first > 600) && (items_in - first < 900);
      if ($urandom_range(99) < 10) begin
        // noise: lone items out of sequence
        send_item($urandom_range(1) ? ModeSolve : ModeLoad,
                  $urandom_range(1) ? rand_target() : rand_coin());
      end else begin
        set_size = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        for (k = 0; k < set_size; k++) send_item(ModeLoad, rand_coin());
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_item(ModeSolve, rand_target());
      end
    end
    steady = 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_change.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = ModeLoad;
    amount_i    = '0;
    out_stall_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_full();
    test_max_target();
    test_backpressure();
    test_random();
    drain_results();

    if (expected_change.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_change.size()));
    $display("Run: %0d transfers in, %0d solves, %0d results checked, %0d unreachable.",
             items_in, solves_in, results_checked, unreachable_in);
    $display("Largest coin set %0d (table full exercised), target 65535 solved, %0d mismatches.",
             peak_coins, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mcc_pkg.sv
sv/min_coin_change_dp.sv
tb/min_coin_change_dp_test.sv
